@@ rtl/core/mcod_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcod_pkg
// Shared types and constants of the matrix-chain order unit: item and result
// structs, ring control, sequencer states and field codes.
// ----------------------------------------------------------------------------
package mcod_pkg;

	localparam int COST_W   = 40;
	localparam int SPLIT_W  = 4;
	localparam int DIM_IN_W = 12;
	localparam int IDX_IN_W = 5;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	// item modes and result kinds
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;
	localparam logic KIND_COST  = 1'b0;
	localparam logic KIND_SPLIT = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [DIM_IN_W-1:0] dimension;
		logic                last;
		logic [IDX_IN_W-1:0] row;
		logic [IDX_IN_W-1:0] col;
	} item_t;

	typedef struct packed {
		logic               kind;
		logic [COST_W-1:0]  min_cost;
		logic [SPLIT_W-1:0] split;
		logic               error;
	} result_t;

	typedef struct packed {
		logic rotate;
		logic load;
	} ring_ctrl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEEK_J,
		S_SEEK_A,
		S_RUN,
		S_DRAIN,
		S_WRITE,
		S_HOME,
		S_QUERY
	} state_t;

endpackage

@@ rtl/core/mcod_dim_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcod_dim_cell
// One slot of the dimension ring: holds one dimension, loads it from the
// item bus when selected and takes its neighbor's value on rotation.
// ----------------------------------------------------------------------------
module mcod_dim_cell #(
	parameter int DW = 12
) (
	input  logic                  clk,
	input  mcod_pkg::ring_ctrl_t  ctrl,
	input  logic                  sel,
	input  logic [DW-1:0]         load_val,
	input  logic [DW-1:0]         nbr_val,
	output logic [DW-1:0]         val
);

	logic [DW-1:0] val_q;

	// load wins over rotation
	always_ff @(posedge clk) begin
		if (ctrl.load && sel) begin
			val_q <= load_val;
		end else if (ctrl.rotate) begin
			val_q <= nbr_val;
		end
	end

	assign val = val_q;

endmodule

@@ rtl/core/mcod_dim_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcod_dim_ring
// Ring of dimension cells. Each rotation moves every value one slot toward
// cell 0, whose value is the single read tap of the ring.
// ----------------------------------------------------------------------------
module mcod_dim_ring #(
	parameter int SLOTS = 17,
	parameter int DW    = 12,
	parameter int IW    = 5
) (
	input  logic                  clk,
	input  mcod_pkg::ring_ctrl_t  ctrl,
	input  logic [IW-1:0]         load_idx,
	input  logic [DW-1:0]         load_val,
	output logic [DW-1:0]         head
);

	logic [DW-1:0] cell_val [SLOTS];

	// cells wired in a closed loop
	for (genvar m = 0; m < SLOTS; m++) begin : g_cell
		mcod_dim_cell #(
			.DW(DW)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.sel      (load_idx == IW'(m)),
			.load_val (load_val),
			.nbr_val  (cell_val[(m + 1) % SLOTS]),
			.val      (cell_val[m])
		);
	end

	assign head = cell_val[0];

endmodule

@@ rtl/core/matrix_chain_order_dp_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_chain_order_dp_unit
// Matrix-chain order solver: loads a chain of dimensions, fills the cost and
// split tables and answers split queries on the stored result.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. Mode 0 items load
//   one dimension each into a ring of cells; no result unless last is set.
//   The item marked last yields one cost result (kind 0); a chain shorter
//   than two or longer than MAX_MATRICES+1 dimensions yields error instead.
//   Mode 1 items query the split of subchain (row, col) and yield one split
//   result (kind 1), with error for a bad or early query.
//   Each result is shown for a single cycle with done high; there is no
//   back pressure on the result side.
// Sequence:
//   load or rejected item: result (if any) in the cycle after the transfer;
//   busy stays low unless a last item starts a table fill. Query: the item
//   passes through S_QUERY and the result is registered from there.
//   Table fill: per table entry (i,j) the ring rotates to pick up p[j] and
//   p[i-1], then j-i steps follow, then pipeline drain and write back;
//   the single read tap of the dimension ring sets this pace.
// Reset:
//   clears the load count, table valid flag and sequencer; tables and
//   dimensions hold no meaning until written again.
// ----------------------------------------------------------------------------
module matrix_chain_order_dp_unit #(
	parameter int MAX_MATRICES = 16,
	parameter int DIM_WIDTH    = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  mcod_pkg::item_t    item,
	output logic               busy,
	output logic               done,
	output mcod_pkg::result_t  result
);

	localparam int SLOTS = MAX_MATRICES + 1;
	localparam int IW    = $clog2(MAX_MATRICES + 2);
	localparam int CW    = $clog2(MAX_MATRICES + 3);
	localparam int AW    = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
	localparam int QW    = (IW > mcod_pkg::IDX_IN_W) ? IW : mcod_pkg::IDX_IN_W;
	localparam int DW    = DIM_WIDTH;
	localparam int PW    = 2 * DW;
	localparam int MEM_D = 1 << (2 * AW);
	localparam int KW    = mcod_pkg::COST_W;

	mcod_pkg::state_t     state_q, state_d;
	mcod_pkg::ring_ctrl_t ring_ctrl;
	mcod_pkg::result_t    emit_res, result_q;
	logic                 emit, done_q;

	logic [IW-1:0] hd_q, n_q, len_q, i_q, j_q, k_q, bestk_q;
	logic [CW-1:0] cnt_q;
	logic          valid_q, first_q;
	logic [DW-1:0] head, c_q;
	logic [PW-1:0] ac_q, ac_d;
	logic [KW-1:0] best_q;

	// inner step pipeline
	logic          v_s1, v_s2, za_s1, zb_s1;
	logic [IW-1:0] k_s1, k_s2;
	logic [PW-1:0] plo_s1, phi_s1, plo_d, phi_d;
	logic [KW-1:0] cost_a_s1, cost_b_s1, prod_s2, sum_s2;

	// tables
	logic [KW-1:0] cost_mem  [MEM_D];
	logic [IW-1:0] split_mem [MEM_D];
	logic [IW-1:0] split_rd_q;
	logic          qeq_q;

	// ---------------------------------------------------------------- load
	logic          cnt_room, chain_bad;
	logic [CW-1:0] cnt_nx;
	logic [IW-1:0] n_nx;

	assign cnt_room  = cnt_q < CW'(SLOTS);
	assign cnt_nx    = cnt_room ? cnt_q + CW'(1) : CW'(SLOTS + 1);
	assign chain_bad = (cnt_nx < CW'(2)) || (cnt_nx > CW'(SLOTS));
	assign n_nx      = IW'(cnt_nx - CW'(1));

	// ---------------------------------------------------------------- query
	logic [QW-1:0] row_w, col_w, rm1, cm1;
	logic          query_bad;
	logic [2*AW-1:0] qaddr;

	assign row_w     = QW'(item.row);
	assign col_w     = QW'(item.col);
	assign rm1       = row_w - QW'(1);
	assign cm1       = col_w - QW'(1);
	assign qaddr     = {rm1[AW-1:0], cm1[AW-1:0]};
	assign query_bad = !valid_q || (item.row == '0) || (col_w > QW'(n_q))
		|| (item.row > item.col);

	// ---------------------------------------------------------------- indexes
	logic [IW-1:0] im1, jm1, km1, k_nx;
	logic [2*AW-1:0] raddr_a, raddr_b, waddr;
	logic          last_pair;

	assign im1       = i_q - IW'(1);
	assign jm1       = j_q - IW'(1);
	assign km1       = k_q - IW'(1);
	assign k_nx      = k_q + IW'(1);
	assign raddr_a   = {im1[AW-1:0], km1[AW-1:0]};
	assign raddr_b   = {k_q[AW-1:0], jm1[AW-1:0]};
	assign waddr     = {im1[AW-1:0], jm1[AW-1:0]};
	assign last_pair = (j_q == n_q) && (len_q == n_q);

	// ---------------------------------------------------------------- ring
	mcod_dim_ring #(
		.SLOTS (SLOTS),
		.DW    (DW),
		.IW    (IW)
	) u_ring (
		.clk      (clk),
		.ctrl     (ring_ctrl),
		.load_idx (IW'(cnt_q)),
		.load_val (DW'(item.dimension)),
		.head     (head)
	);

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d   = state_q;
		ring_ctrl = '0;
		emit      = 1'b0;
		emit_res  = '0;
		case (state_q)
			mcod_pkg::S_IDLE: begin
				if (start) begin
					if (item.mode == mcod_pkg::MODE_LOAD) begin
						ring_ctrl.load = cnt_room;
						if (item.last) begin
							if (chain_bad) begin
								emit           = 1'b1;
								emit_res.kind  = mcod_pkg::KIND_COST;
								emit_res.error = 1'b1;
							end else if (n_nx == IW'(1)) begin
								emit          = 1'b1;
								emit_res.kind = mcod_pkg::KIND_COST;
							end else begin
								state_d = mcod_pkg::S_SEEK_J;
							end
						end
					end else begin
						if (query_bad) begin
							emit           = 1'b1;
							emit_res.kind  = mcod_pkg::KIND_SPLIT;
							emit_res.error = 1'b1;
						end else begin
							state_d = mcod_pkg::S_QUERY;
						end
					end
				end
			end
			mcod_pkg::S_SEEK_J: begin
				ring_ctrl.rotate = 1'b1;
				if (hd_q == j_q) state_d = mcod_pkg::S_SEEK_A;
			end
			mcod_pkg::S_SEEK_A: begin
				ring_ctrl.rotate = 1'b1;
				if (hd_q == im1) state_d = mcod_pkg::S_RUN;
			end
			mcod_pkg::S_RUN: begin
				ring_ctrl.rotate = 1'b1;
				if (k_nx == j_q) state_d = mcod_pkg::S_DRAIN;
			end
			mcod_pkg::S_DRAIN: begin
				if (!v_s1 && !v_s2) state_d = mcod_pkg::S_WRITE;
			end
			mcod_pkg::S_WRITE: begin
				state_d = last_pair ? mcod_pkg::S_HOME : mcod_pkg::S_SEEK_J;
			end
			mcod_pkg::S_HOME: begin
				if (hd_q == '0) begin
					emit              = 1'b1;
					emit_res.kind     = mcod_pkg::KIND_COST;
					emit_res.min_cost = best_q;
					state_d           = mcod_pkg::S_IDLE;
				end else begin
					ring_ctrl.rotate = 1'b1;
				end
			end
			mcod_pkg::S_QUERY: begin
				emit           = 1'b1;
				emit_res.kind  = mcod_pkg::KIND_SPLIT;
				emit_res.split = qeq_q ? '0 : mcod_pkg::SPLIT_W'(split_rd_q);
				state_d        = mcod_pkg::S_IDLE;
			end
			default: begin
				state_d = mcod_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcod_pkg::S_IDLE;
			hd_q    <= '0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
			done_q  <= 1'b0;
			first_q <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			v_s1    <= (state_q == mcod_pkg::S_RUN);
			v_s2    <= v_s1;
			if (ring_ctrl.rotate) begin
				hd_q <= (hd_q == IW'(SLOTS - 1)) ? '0 : hd_q + IW'(1);
			end
			// chain load and table valid flag
			if (state_q == mcod_pkg::S_IDLE && start && item.mode == mcod_pkg::MODE_LOAD) begin
				cnt_q   <= item.last ? '0 : cnt_nx;
				valid_q <= item.last && !chain_bad && (n_nx == IW'(1));
			end
			if (state_q == mcod_pkg::S_HOME && hd_q == '0) valid_q <= 1'b1;
			// first candidate of each entry
			if (state_q == mcod_pkg::S_SEEK_A && hd_q == im1) begin
				first_q <= 1'b1;
			end else if (v_s2) begin
				first_q <= 1'b0;
			end
		end
	end

	// loop counters and operand latches
	assign ac_d = head * c_q;

	always_ff @(posedge clk) begin
		if (state_q == mcod_pkg::S_IDLE && start && item.mode == mcod_pkg::MODE_LOAD
			&& item.last) begin
			n_q   <= n_nx;
			len_q <= IW'(2);
			i_q   <= IW'(1);
			j_q   <= IW'(2);
		end
		if (state_q == mcod_pkg::S_SEEK_J && hd_q == j_q) c_q <= head;
		if (state_q == mcod_pkg::S_SEEK_A && hd_q == im1) begin
			ac_q <= ac_d;
			k_q  <= i_q;
		end
		if (state_q == mcod_pkg::S_RUN) k_q <= k_nx;
		if (state_q == mcod_pkg::S_WRITE) begin
			if (j_q == n_q) begin
				len_q <= len_q + IW'(1);
				i_q   <= IW'(1);
				j_q   <= len_q + IW'(1);
			end else begin
				i_q <= i_q + IW'(1);
				j_q <= j_q + IW'(1);
			end
		end
	end

	// ---------------------------------------------------------------- step pipeline
	assign plo_d = ac_q[DW-1:0] * head;
	assign phi_d = ac_q[PW-1:DW] * head;

	logic [63:0]   prod_full;
	logic [KW:0]   sum_ab, sum_q;
	logic [KW-1:0] op_a, op_b, q_val;

	assign prod_full = (64'(phi_s1) << DW) + 64'(plo_s1);
	assign op_a      = za_s1 ? '0 : cost_a_s1;
	assign op_b      = zb_s1 ? '0 : cost_b_s1;
	assign sum_ab    = {1'b0, op_a} + {1'b0, op_b};
	assign sum_q     = {1'b0, prod_s2} + {1'b0, sum_s2};
	assign q_val     = sum_q[KW] ? mcod_pkg::COST_MAX : sum_q[KW-1:0];

	// stage 1: partial products of p[i-1]*p[j]*p[k], table reads in flight
	always_ff @(posedge clk) begin
		k_s1   <= k_q;
		za_s1  <= (k_q == i_q);
		zb_s1  <= (k_nx == j_q);
		plo_s1 <= plo_d;
		phi_s1 <= phi_d;
	end

	// stage 2: saturated product and saturated cost sum
	always_ff @(posedge clk) begin
		k_s2    <= k_s1;
		prod_s2 <= (prod_full > 64'(mcod_pkg::COST_MAX)) ? mcod_pkg::COST_MAX
			: prod_full[KW-1:0];
		sum_s2  <= sum_ab[KW] ? mcod_pkg::COST_MAX : sum_ab[KW-1:0];
	end

	// stage 3: running minimum, smallest split wins on ties
	always_ff @(posedge clk) begin
		if (v_s2 && (first_q || q_val < best_q)) begin
			best_q  <= q_val;
			bestk_q <= k_s2;
		end
	end

	// ---------------------------------------------------------------- tables
	always_ff @(posedge clk) begin
		if (state_q == mcod_pkg::S_WRITE) cost_mem[waddr] <= best_q;
		cost_a_s1 <= cost_mem[raddr_a];
		cost_b_s1 <= cost_mem[raddr_b];
	end

	always_ff @(posedge clk) begin
		if (state_q == mcod_pkg::S_WRITE) split_mem[waddr] <= bestk_q;
		split_rd_q <= split_mem[qaddr];
		qeq_q      <= (item.row == item.col);
	end

	// ---------------------------------------------------------------- result
	always_ff @(posedge clk) begin
		result_q <= emit_res;
	end

	assign busy   = (state_q != mcod_pkg::S_IDLE);
	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	// ring tap lines up with the split index during the inner loop
	a_ring_align: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mcod_pkg::S_RUN) |-> (hd_q == k_q))
		else $error("ring tap out of step with split index");

	// ring is back home whenever new dimensions may load
	a_ring_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mcod_pkg::S_IDLE) |-> (hd_q == '0))
		else $error("ring not at home slot while idle");

	// write back only after the step pipeline has drained
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mcod_pkg::S_WRITE) |-> (!v_s1 && !v_s2))
		else $error("table write with steps still in flight");

	// load count never passes the overflow mark
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(SLOTS + 1))
		else $error("load count beyond overflow mark");
`endif

endmodule

@@ test/tb_matrix_chain_order_dp_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_chain_order_dp_unit
// Self-checking bench for the matrix-chain order unit. Dimension chains are
// loaded, the minimum cost is checked against a local dynamic-programming
// predictor, and split queries are checked against the predicted split table.
// Directed cases cover short, long and overflowing chains and bad or early
// queries. Random chains follow, with sender gaps at two densities and then
// none.
// ----------------------------------------------------------------------------
module tb_matrix_chain_order_dp_unit;

	localparam int NMAX      = 16;
	localparam int SLOTS     = NMAX + 1;
	localparam int CYCLE_CAP = 3000000;

	logic              clk;
	logic              arst_n;
	logic              start;
	mcod_pkg::item_t   item;
	logic              busy;
	logic              done;
	mcod_pkg::result_t result;

	matrix_chain_order_dp_unit #(
		.MAX_MATRICES(NMAX),
		.DIM_WIDTH(12)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result)
	);

	// clock, period 2 ns
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// predictor state: loaded chain and filled tables
	logic [63:0] chain_dims [0:SLOTS-1];
	logic [63:0] best_cost [0:SLOTS-1][0:SLOTS-1];
	logic [3:0]  best_split [0:SLOTS-1][0:SLOTS-1];
	int          dims_loaded;
	bit          tables_ok;
	int          n_matrices;

	mcod_pkg::result_t pending_results[$];
	int      transfers;
	int      fail_count;
	int      cycle_count;
	int      gap_pct;
	int      cost_answers, split_answers, error_answers;

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s > 64'(mcod_pkg::COST_MAX)) ? 64'(mcod_pkg::COST_MAX) : s;
	endfunction

	// classic O(n^3) fill, smallest split index wins on ties
	task automatic fill_chain_tables(input int n);
		logic [63:0] q, best;
		int          j, bk;
		for (int i = 1; i <= n; i++) begin
			best_cost[i][i] = '0;
			best_split[i][i] = '0;
		end
		for (int len = 2; len <= n; len++) begin
			for (int i = 1; i + len - 1 <= n; i++) begin
				j = i + len - 1;
				best = '0;
				bk = i;
				for (int k = i; k < j; k++) begin
					q = add_sat(add_sat(best_cost[i][k], best_cost[k+1][j]),
						chain_dims[i-1] * chain_dims[k] * chain_dims[j]);
					if (k == i || q < best) begin
						best = q;
						bk = k;
					end
				end
				best_cost[i][j] = best;
				best_split[i][j] = 4'(bk);
			end
		end
	endtask

	task automatic predict_chain_step(input mcod_pkg::item_t it, output bit has,
			output mcod_pkg::result_t r);
		r = '0;
		r.kind = it.mode;
		has = 1'b1;
		if (it.mode == mcod_pkg::MODE_LOAD) begin
			tables_ok = 1'b0;
			if (dims_loaded < SLOTS) begin
				chain_dims[dims_loaded] = 64'(it.dimension);
				dims_loaded++;
			end else begin
				dims_loaded = SLOTS + 1;
			end
			if (!it.last) begin
				has = 1'b0;
				return;
			end
			if (dims_loaded < 2 || dims_loaded > SLOTS) begin
				r.error = 1'b1;
			end else begin
				n_matrices = dims_loaded - 1;
				fill_chain_tables(n_matrices);
				tables_ok = 1'b1;
				r.min_cost = best_cost[1][n_matrices][mcod_pkg::COST_W-1:0];
			end
			dims_loaded = 0;
		end else begin
			if (!tables_ok || it.row < 1 || it.col > n_matrices || it.row > it.col)
				r.error = 1'b1;
			else if (it.row != it.col)
				r.split = best_split[it.row][it.col];
		end
	endtask

	// result check first, then prediction of the transfer at this edge
	always @(posedge clk) begin
		mcod_pkg::result_t exp_r;
		bit      has;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_CAP) begin
				$display("%0t: timeout after %0d cycles", $time, cycle_count);
				$display("CHECKS FAILED");
				$finish;
			end
			if (done) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, actual %p", $time, result);
				end else begin
					exp_r = pending_results.pop_front();
					if (result.kind !== exp_r.kind) begin
						fail_count++;
						$display("%0t: kind expected %0d actual %0d",
							$time, exp_r.kind, result.kind);
					end
					if (result.min_cost !== exp_r.min_cost) begin
						fail_count++;
						$display("%0t: min_cost expected %0d actual %0d",
							$time, exp_r.min_cost, result.min_cost);
					end
					if (result.split !== exp_r.split) begin
						fail_count++;
						$display("%0t: split expected %0d actual %0d",
							$time, exp_r.split, result.split);
					end
					if (result.error !== exp_r.error) begin
						fail_count++;
						$display("%0t: error expected %0d actual %0d",
							$time, exp_r.error, result.error);
					end
					if (exp_r.error) error_answers++;
					else if (exp_r.kind == mcod_pkg::KIND_COST) cost_answers++;
					else split_answers++;
				end
			end
			if (start && !busy) begin
				predict_chain_step(item, has, exp_r);
				if (has) pending_results.push_back(exp_r);
				transfers++;
			end
		end
	end

	// one transfer; start stays high on return
	task automatic send_item(input mcod_pkg::item_t it);
		int seen;
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		seen = transfers;
		do @(negedge clk); while (transfers == seen);
	endtask

	function automatic mcod_pkg::item_t make_item(input logic m, input logic [11:0] d,
			input logic l, input logic [4:0] r, input logic [4:0] c);
		mcod_pkg::item_t it;
		it.mode = m;
		it.dimension = d;
		it.last = l;
		it.row = r;
		it.col = c;
		return it;
	endfunction

	task automatic load_chain(input int ndims, input bit full_range);
		logic [11:0] d;
		for (int i = 0; i < ndims; i++) begin
			d = full_range ? 12'($urandom) : 12'($urandom_range(20));
			send_item(make_item(mcod_pkg::MODE_LOAD, d, i == ndims - 1,
				5'($urandom), 5'($urandom)));
		end
	endtask

	// early query, short chains, extremes, every bad query form
	task automatic test_directed();
		send_item(make_item(mcod_pkg::MODE_QUERY, 12'hfff, 1'b1, 5'd1, 5'd1));
		send_item(make_item(mcod_pkg::MODE_LOAD, 12'd7, 1'b1, 5'd0, 5'd0));
		send_item(make_item(mcod_pkg::MODE_LOAD, 12'd0, 1'b0, 5'd31, 5'd31));
		send_item(make_item(mcod_pkg::MODE_LOAD, 12'hfff, 1'b1, 5'd0, 5'd0));
		send_item(make_item(mcod_pkg::MODE_QUERY, 12'd0, 1'b0, 5'd1, 5'd1));
		for (int i = 0; i < 4; i++)
			send_item(make_item(mcod_pkg::MODE_LOAD, 12'(i * 3 + 2), i == 3,
				5'd0, 5'd0));
		send_item(make_item(mcod_pkg::MODE_QUERY, 12'd0, 1'b0, 5'd1, 5'd3));
		send_item(make_item(mcod_pkg::MODE_QUERY, 12'd0, 1'b0, 5'd2, 5'd3));
		send_item(make_item(mcod_pkg::MODE_QUERY, 12'd0, 1'b0, 5'd0, 5'd2));
		send_item(make_item(mcod_pkg::MODE_QUERY, 12'd0, 1'b0, 5'd1, 5'd4));
		send_item(make_item(mcod_pkg::MODE_QUERY, 12'd0, 1'b0, 5'd3, 5'd2));
		send_item(make_item(mcod_pkg::MODE_QUERY, 12'd0, 1'b1, 5'd31, 5'd31));
		send_item(make_item(mcod_pkg::MODE_QUERY, 12'd0, 1'b0, 5'd3, 5'd3));
		// a lone load invalidates the tables
		send_item(make_item(mcod_pkg::MODE_LOAD, 12'd5, 1'b0, 5'd0, 5'd0));
		send_item(make_item(mcod_pkg::MODE_QUERY, 12'd0, 1'b0, 5'd1, 5'd2));
		send_item(make_item(mcod_pkg::MODE_LOAD, 12'd6, 1'b1, 5'd0, 5'd0));
		send_item(make_item(mcod_pkg::MODE_QUERY, 12'd0, 1'b0, 5'd1, 5'd1));
	endtask

	// longest legal chains, all-ones and random, then overflowing chains
	task automatic test_chain_extremes();
		for (int i = 0; i < SLOTS; i++)
			send_item(make_item(mcod_pkg::MODE_LOAD, 12'hfff, i == SLOTS - 1,
				5'd0, 5'd0));
		send_item(make_item(mcod_pkg::MODE_QUERY, 12'd0, 1'b0, 5'd1, 5'd16));
		send_item(make_item(mcod_pkg::MODE_QUERY, 12'd0, 1'b0, 5'd16, 5'd16));
		send_item(make_item(mcod_pkg::MODE_QUERY, 12'd0, 1'b0, 5'd16, 5'd17));
		load_chain(SLOTS, 1'b1);
		for (int q = 0; q < 6; q++) begin
			send_item(make_item(mcod_pkg::MODE_QUERY, 12'($urandom), 1'($urandom),
				5'($urandom_range(16, 1)), 5'd16));
		end
		load_chain(SLOTS + 1, 1'b1);
		send_item(make_item(mcod_pkg::MODE_QUERY, 12'd0, 1'b0, 5'd1, 5'd2));
		load_chain(SLOTS + 4, 1'b0);
	endtask

	// mostly well-formed chains with queries, some noise
	task automatic test_random_chains(input int budget, input int pct);
		int used, ndims, nq, r, c;
		gap_pct = pct;
		used = 0;
		while (used < budget) begin
			r = $urandom_range(99);
			if (r < 85) ndims = $urandom_range(7, 3);
			else if (r < 91) ndims = $urandom_range(SLOTS, 8);
			else if (r < 95) ndims = $urandom_range(2, 1);
			else ndims = $urandom_range(SLOTS + 3, SLOTS + 1);
			load_chain(ndims, 1'($urandom_range(1)));
			used += ndims;
			nq = $urandom_range(10);
			for (int q = 0; q < nq; q++) begin
				if ($urandom_range(9) < 8) begin
					c = $urandom_range(ndims > 1 ? ndims - 1 : 1, 1);
					r = $urandom_range(c, 1);
				end else begin
					c = $urandom_range(31);
					r = $urandom_range(31);
				end
				send_item(make_item(mcod_pkg::MODE_QUERY, 12'($urandom), 1'($urandom),
					5'(r), 5'(c)));
			end
			used += nq;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		gap_pct = 0;
		transfers = 0;
		fail_count = 0;
		cycle_count = 0;
		cost_answers = 0;
		split_answers = 0;
		error_answers = 0;
		dims_loaded = 0;
		tables_ok = 1'b0;
		n_matrices = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_chain_extremes();
		test_random_chains(560, 16);
		test_random_chains(560, 58);
		test_random_chains(560, 0);
		start <= 1'b0;

		while (pending_results.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);

		$display("covered %0d transfers: %0d cost answers, %0d split answers, %0d errors",
			transfers, cost_answers, split_answers, error_answers);
		$display("chains of 1 to 21 dimensions, gaps at 16%% and 58%% and none");
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ matrix_chain_order_dp_unit.f @@
rtl/core/mcod_pkg.sv
rtl/core/mcod_dim_cell.sv
rtl/core/mcod_dim_ring.sv
rtl/core/matrix_chain_order_dp_unit.sv
test/tb_matrix_chain_order_dp_unit.sv
